>>> sv/lsbm_pkg.sv
// Package for the load/store byte memory: sizes, size codes, FSM encoding,
// and the control/status structs between controller and datapath.
// No dependencies.
package lsbm_pkg;

   localparam int MEM_BYTES = 1024;
   localparam int ADDR_W    = $clog2(MEM_BYTES);

   localparam logic [2:0] CODE_B  = 3'd0;
   localparam logic [2:0] CODE_H  = 3'd1;
   localparam logic [2:0] CODE_W  = 3'd2;
   localparam logic [2:0] CODE_D  = 3'd3;
   localparam logic [2:0] CODE_BU = 3'd4;
   localparam logic [2:0] CODE_HU = 3'd5;
   localparam logic [2:0] CODE_WU = 3'd6;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_ACCESS = 5'b00100,
      ST_LAST   = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic access_ok;
      logic is_store;
      logic step_last;
   } status_type;

endpackage

>>> sv/lsbm_if.sv
// Handshake channels for the load/store byte memory: request and response.
// No dependencies.
interface lsbm_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] addr;
   logic [2:0]  size_code;
   logic [31:0] store_data;

   modport source (output valid, req_type, addr, size_code, store_data, input ready);
   modport sink   (input valid, req_type, addr, size_code, store_data, output ready);
endinterface

interface lsbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] load_data;
   logic        out_of_range;

   modport source (output valid, load_data, out_of_range, input ready);
   modport sink   (input valid, load_data, out_of_range, output ready);
endinterface

>>> sv/lsbm_ram.sv
// Generic single-port RAM, one write or read per cycle, registered read data.
// No dependencies.
module lsbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/lsbm_dp.sv
// Datapath: request registers, range check, byte sequencing over the RAM,
// load assembly and extension, clearing counter.
// Depends on lsbm_pkg and lsbm_ram.
module lsbm_dp import lsbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        req_type,
   input  logic [31:0] addr,
   input  logic [2:0]  size_code,
   input  logic [31:0] store_data,
   output logic [31:0] load_data,
   output logic        out_of_range
);

   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [2:0]        idx_ff, idx_in;
   logic              cap_ff, cap_in;
   logic [1:0]        cap_idx_ff, cap_idx_in;
   logic              store_ff, store_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [3:0]        len_ff, len_in;
   logic [2:0]        code_ff, code_in;
   logic [31:0]       data_ff, data_in;
   logic              fault_ff, fault_in;
   logic [31:0]       result_ff, result_in;

   logic [3:0]        req_len;
   logic [32:0]       last_byte;
   logic              fits;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [7:0]        ram_wdata;
   logic [7:0]        ram_rdata;

   always_comb begin
      req_len = 4'd0;
      if (req_type) begin
         unique case (size_code)
            CODE_B:  req_len = 4'd1;
            CODE_H:  req_len = 4'd2;
            CODE_W:  req_len = 4'd4;
            CODE_D:  req_len = 4'd8;
            default: req_len = 4'd0;
         endcase
      end else begin
         unique case (size_code)
            CODE_B, CODE_BU: req_len = 4'd1;
            CODE_H, CODE_HU: req_len = 4'd2;
            CODE_W, CODE_WU: req_len = 4'd4;
            default:         req_len = 4'd0;
         endcase
      end
   end

   assign last_byte = 33'(addr) + 33'(req_len) - 33'd1;
   assign fits      = last_byte < 33'(MEM_BYTES);

   always_comb begin
      clr_in     = clr_ff;
      idx_in     = idx_ff;
      cap_in     = 1'b0;
      cap_idx_in = idx_ff[1:0];
      store_in   = store_ff;
      base_in    = base_ff;
      len_in     = len_ff;
      code_in    = code_ff;
      data_in    = data_ff;
      fault_in   = fault_ff;
      result_in  = result_ff;
      if (cmd.clear) begin
         clr_in = clr_ff + ADDR_W'(1);
      end
      if (cmd.accept) begin
         store_in  = req_type;
         base_in   = addr[ADDR_W-1:0];
         len_in    = req_len;
         code_in   = size_code;
         data_in   = store_data;
         fault_in  = (req_len != 4'd0) && !fits;
         result_in = '0;
         idx_in    = '0;
      end
      if (cmd.step) begin
         idx_in = idx_ff + 3'd1;
         cap_in = !store_ff;
      end
      if (cap_ff) begin
         result_in[8*cap_idx_ff +: 8] = ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         idx_ff <= '0;
         cap_ff <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         idx_ff <= idx_in;
         cap_ff <= cap_in;
      end
      cap_idx_ff <= cap_idx_in;
      store_ff   <= store_in;
      base_ff    <= base_in;
      len_ff     <= len_in;
      code_ff    <= code_in;
      data_ff    <= data_in;
      fault_ff   <= fault_in;
      result_ff  <= result_in;
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = base_ff + ADDR_W'(idx_ff);
      ram_wdata = idx_ff[2] ? 8'h00 : data_ff[8*idx_ff[1:0] +: 8];
      if (cmd.clear) begin
         ram_we    = 1'b1;
         ram_addr  = clr_ff;
         ram_wdata = 8'h00;
      end else if (cmd.step) begin
         ram_we = store_ff;
      end
   end

   lsbm_ram #(
      .WIDTH (8),
      .DEPTH (MEM_BYTES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign status.clear_done = clr_ff == ADDR_W'(MEM_BYTES - 1);
   assign status.access_ok  = (req_len != 4'd0) && fits;
   assign status.is_store   = store_ff;
   assign status.step_last  = {1'b0, idx_ff} == (len_ff - 4'd1);

   always_comb begin
      load_data = result_ff;
      if (code_ff == CODE_B && !store_ff) begin
         load_data = {{24{result_ff[7]}}, result_ff[7:0]};
      end else if (code_ff == CODE_H && !store_ff) begin
         load_data = {{16{result_ff[15]}}, result_ff[15:0]};
      end
   end

   assign out_of_range = fault_ff;

endmodule

>>> sv/lsbm_ctrl.sv
// Controller FSM: clearing pass, request accept, byte steps, response.
// Depends on lsbm_pkg.
module lsbm_ctrl import lsbm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = status.access_ok ? ST_ACCESS : ST_RESP;
         end
         ST_ACCESS: begin
            if (status.step_last) state_in = status.is_store ? ST_RESP : ST_LAST;
         end
         ST_LAST: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready  = state_ff == ST_IDLE;
   assign rsp_valid  = state_ff == ST_RESP;
   assign cmd.clear  = state_ff == ST_CLEAR;
   assign cmd.accept = req_ready && req_valid;
   assign cmd.step   = state_ff == ST_ACCESS;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> state_ff == ST_CLEAR)
      else $error("reset did not start clearing pass");

   a_fault_direct: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && !status.access_ok |=> state_ff == ST_RESP)
      else $error("suppressed access touched memory");

   a_store_done: assert property (@(posedge clock) disable iff (reset)
      cmd.step && status.step_last && status.is_store |=> state_ff == ST_RESP)
      else $error("store did not finish after last byte");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

>>> sv/load_store_byte_memory.sv
// Load/store byte memory: a load (1, 2 or 4 bytes) or store (1, 2, 4 or 8
// bytes) moves one byte per cycle through the RAM port, a load then passing
// ST_LAST before response valid; a suppressed or unsupported access goes
// straight to response valid. One item at a time: the next item is accepted
// after the response is taken. Reset (synchronous) starts a pass zeroing all
// MEM_BYTES (1024) bytes; no item is accepted until that clearing pass ends.
module load_store_byte_memory import lsbm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   lsbm_req_if.sink  req_port,
   lsbm_rsp_if.source rsp_port
);

   cmd_type    cmd;
   status_type status;

   lsbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lsbm_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_type     (req_port.req_type),
      .addr         (req_port.addr),
      .size_code    (req_port.size_code),
      .store_data   (req_port.store_data),
      .load_data    (rsp_port.load_data),
      .out_of_range (rsp_port.out_of_range)
   );

endmodule
